### src/itf_pkg.sv
// Package for the integer-to-text formatter: request/result payload types,
// flag bit positions, character codes and the digit function. No dependencies.
package itf_pkg;

  localparam int unsigned OutLimitDef  = 64;
  localparam int unsigned ValueBitsDef = 64;

  localparam int unsigned FlZero   = 0;
  localparam int unsigned FlSigned = 1;
  localparam int unsigned FlPlus   = 2;
  localparam int unsigned FlSpace  = 3;
  localparam int unsigned FlLeft   = 4;
  localparam int unsigned FlPrefix = 5;
  localparam int unsigned FlUpper  = 6;

  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChMinus  = 8'h2d;
  localparam logic [7:0] ChPlus   = 8'h2b;
  localparam logic [7:0] ChLowerX = 8'h78;
  localparam logic [7:0] ChUpperX = 8'h58;

  typedef struct packed {
    logic [63:0] value;
    logic [5:0]  base;
    logic [6:0]  width;
    logic [6:0]  precision;
    logic [6:0]  flags;
  } req_t;

  typedef struct packed {
    logic [7:0] character;
    logic       empty_res;
    logic       last;
    logic       truncated;
    logic [6:0] char_count;
  } res_t;

  // Job handed from the front to the back: digits are worked out there.
  typedef struct packed {
    logic        bad;
    logic [63:0] mag;
    logic [5:0]  base;
    logic [6:0]  width;
    logic [6:0]  precision;
    logic [7:0]  sign;
    logic [1:0]  prefix;
    logic        zpad;
    logic        left;
    logic        upper;
  } job_t;

  typedef enum logic [3:0] {
    BkIdle, BkDiv, BkLpad, BkSign, BkPfx0, BkPfx1, BkZero, BkDigit, BkRpad
  } bk_state_e;

  // Digit value to ASCII, upper or lower case.
  function automatic logic [7:0] digit_char(logic [5:0] d, logic upper);
    if (d < 6'd10) return ChZero + {2'b00, d};
    return (upper ? 8'h41 : 8'h61) + {2'b00, d} - 8'd10;
  endfunction

endpackage

### src/itf_front.sv
// Front end: accepts a request, works out sign, magnitude and prefix, and
// pushes a job into a two-entry queue. Depends on itf_pkg.
module itf_front import itf_pkg::*; #(
  parameter int unsigned ValueBits = ValueBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic job_valid_o,
  input  logic job_ready_i,
  output job_t job_o
);

  logic [1:0] cnt_q, cnt_d;
  logic       wp_q, rp_q;
  job_t       fifo_q [2];
  job_t       job_d;
  logic [ValueBits-1:0] v;
  logic [6:0] fl;
  logic push, pop;

  // Classify the request
  always_comb begin
    v  = in_req_i.value[ValueBits-1:0];
    fl = in_req_i.flags;
    job_d = '0;
    job_d.bad = (in_req_i.base < 6'd2) || (in_req_i.base > 6'd36);
    job_d.base = in_req_i.base;
    job_d.width = in_req_i.width;
    job_d.precision = in_req_i.precision;
    job_d.left = fl[FlLeft];
    job_d.zpad = fl[FlZero] & ~fl[FlLeft];
    job_d.upper = fl[FlUpper];
    job_d.mag = 64'(v);
    if (fl[FlSigned]) begin
      if (v[ValueBits-1]) begin
        job_d.sign = ChMinus;
        job_d.mag = 64'(ValueBits'(-v));
      end else if (fl[FlPlus]) begin
        job_d.sign = ChPlus;
      end else if (fl[FlSpace]) begin
        job_d.sign = ChSpace;
      end
    end
    if (fl[FlPrefix]) begin
      if (in_req_i.base == 6'd16) job_d.prefix = 2'd2;
      else if (in_req_i.base == 6'd8) job_d.prefix = 2'd1;
    end
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = fifo_q[rp_q];
  assign push = in_valid_i & in_ready_o;
  assign pop  = job_valid_o & job_ready_i;
  assign cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};

  // Queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= job_d;
  end

endmodule

### src/itf_back.sv
// Back end: a bit-serial divider stacks the digits, then a segment sequencer
// emits one character per cycle while the output is not held. Depends on itf_pkg.
module itf_back import itf_pkg::*; #(
  parameter int unsigned OutLimit = OutLimitDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_valid_i,
  output logic job_ready_o,
  input  job_t job_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_res_o
);

  localparam logic [7:0] LimMax = 8'(OutLimit);

  bk_state_e    st_q, st_d;
  job_t         job_q;
  logic [63:0]  quo_q, quo_d;     // dividend, replaced by quotient bits from the top
  logic [5:0]   rem_q, rem_d;
  logic [5:0]   bit_q, bit_d;     // bit index of the divider
  logic [6:0]   nd_q, nd_d;       // digits on the stack
  logic [383:0] stk_q, stk_d;     // digit stack, top in the low six bits
  logic [7:0]   run_q, run_d;     // characters left in the current segment
  logic [7:0]   zeros_q, zeros_d;
  logic [7:0]   rpad_q, rpad_d;
  logic [7:0]   lim_q, lim_d;     // characters that will be emitted
  logic         trunc_q, trunc_d;
  logic [7:0]   kept_q, kept_d;
  logic         ov_q, ov_d;
  res_t         res_q, res_d;

  logic         free, take, emit, lst;
  logic [7:0]   ch, cnt;
  logic [6:0]   rem_sh;
  logic         ge;
  logic [5:0]   dig;
  logic [6:0]   nd_inc;
  logic [6:0]   body;
  logic [7:0]   fixed, pad, total;

  assign free = !ov_q || out_ready_i;
  assign take = (st_q == BkIdle) && job_valid_i && free;
  assign job_ready_o = (st_q == BkIdle) && free;
  assign out_valid_o = ov_q;
  assign out_res_o = res_q;
  assign nd_inc = nd_q + 7'd1;

  // Layout of the text once the last digit is known
  always_comb begin
    body  = (job_q.precision > nd_inc) ? job_q.precision : nd_inc;
    fixed = {1'b0, body} + {6'd0, job_q.prefix} + ((job_q.sign != 8'd0) ? 8'd1 : 8'd0);
    pad   = ({1'b0, job_q.width} > fixed) ? ({1'b0, job_q.width} - fixed) : 8'd0;
    total = fixed + pad;
  end

  // Divider and character sequencer
  always_comb begin
    st_d = st_q; quo_d = quo_q; rem_d = rem_q; bit_d = bit_q; nd_d = nd_q;
    stk_d = stk_q; run_d = run_q; zeros_d = zeros_q; rpad_d = rpad_q;
    lim_d = lim_q; trunc_d = trunc_q; kept_d = kept_q;
    ov_d = ov_q && !out_ready_i; res_d = res_q;
    emit = 1'b0; ch = ChSpace;
    rem_sh = {rem_q, quo_q[bit_q]};
    ge = (rem_sh >= {1'b0, job_q.base});
    dig = ge ? 6'(rem_sh - {1'b0, job_q.base}) : rem_sh[5:0];
    cnt = kept_q + 8'd1;
    lst = (cnt == lim_q);
    case (st_q)
      BkIdle: begin
        if (take) begin
          if (job_i.bad) begin
            ov_d = 1'b1;
            res_d = '0; res_d.empty_res = 1'b1; res_d.last = 1'b1;
          end else begin
            st_d = BkDiv; quo_d = job_i.mag; rem_d = '0; bit_d = 6'd63;
            nd_d = '0; kept_d = '0;
          end
        end
      end
      // one quotient bit per cycle, digits pushed least significant first
      BkDiv: begin
        rem_d = dig; quo_d[bit_q] = ge; bit_d = bit_q - 6'd1;
        if (bit_q == 6'd0) begin
          stk_d = {stk_q[377:0], dig}; nd_d = nd_inc; rem_d = '0;
          if (quo_d == 64'd0) begin
            run_d = (job_q.zpad || job_q.left) ? 8'd0 : pad;
            zeros_d = (job_q.zpad ? pad : 8'd0) + {1'b0, 7'(body - nd_inc)};
            rpad_d = job_q.left ? pad : 8'd0;
            trunc_d = (total > LimMax);
            lim_d = trunc_d ? LimMax : total;
            st_d = BkLpad;
          end
        end
      end
      BkLpad: if (free) begin
        if (run_q != 8'd0) begin
          emit = 1'b1; ch = ChSpace; run_d = run_q - 8'd1;
          if (run_q == 8'd1) st_d = BkSign;
        end else begin
          st_d = BkSign;
        end
      end
      BkSign: if (free) begin
        if (job_q.sign != 8'd0) begin
          emit = 1'b1; ch = job_q.sign;
        end
        st_d = BkPfx0;
      end
      BkPfx0: if (free) begin
        if (job_q.prefix != 2'd0) begin
          emit = 1'b1; ch = ChZero;
        end
        st_d = BkPfx1;
      end
      BkPfx1: if (free) begin
        if (job_q.prefix == 2'd2) begin
          emit = 1'b1; ch = job_q.upper ? ChUpperX : ChLowerX;
        end
        run_d = zeros_q; st_d = BkZero;
      end
      BkZero: if (free) begin
        if (run_q != 8'd0) begin
          emit = 1'b1; ch = ChZero; run_d = run_q - 8'd1;
          if (run_q == 8'd1) st_d = BkDigit;
        end else begin
          st_d = BkDigit;
        end
      end
      // most significant digit sits on top of the stack
      BkDigit: if (free) begin
        emit = 1'b1; ch = digit_char(stk_q[5:0], job_q.upper);
        stk_d = {6'd0, stk_q[383:6]}; nd_d = nd_q - 7'd1;
        if (nd_q == 7'd1) begin
          run_d = rpad_q; st_d = BkRpad;
        end
      end
      BkRpad: if (free) begin
        if (run_q != 8'd0) begin
          emit = 1'b1; ch = ChSpace; run_d = run_q - 8'd1;
        end else begin
          st_d = BkIdle;
        end
      end
      default: st_d = BkIdle;
    endcase
    // Output register; the text ends at the last kept character
    if (emit) begin
      ov_d = 1'b1; kept_d = cnt;
      res_d = '0; res_d.character = ch; res_d.char_count = cnt[6:0];
      res_d.last = lst; res_d.truncated = lst && trunc_q;
      if (lst) st_d = BkIdle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BkIdle; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) job_q <= job_i;
    quo_q <= quo_d; rem_q <= rem_d; bit_q <= bit_d; nd_q <= nd_d; stk_q <= stk_d;
    run_q <= run_d; zeros_q <= zeros_d; rpad_q <= rpad_d; lim_q <= lim_d;
    trunc_q <= trunc_d; kept_q <= kept_d; res_q <= res_d;
  end

endmodule

### src/integer_to_text_formatter.sv
// Integer-to-text formatter: takes one request (value, base, width, precision,
// flags) and returns the printf-style text one character per result. A request
// is classified in the front end and waits in a two-entry queue. The back end
// takes it, then works out each digit on a bit-serial divider (a zero value
// counts as one digit), then emits one character per cycle while the output is
// not held, with an extra step for each empty segment among leading spaces,
// sign, the two prefix characters and the zero run. An invalid base gives a
// single empty result, registered when the back end takes the request. Output
// back-pressure stalls the back end.
module integer_to_text_formatter import itf_pkg::*; #(
  parameter int unsigned OutLimit  = OutLimitDef,
  parameter int unsigned ValueBits = ValueBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_res_o
);

  logic job_valid, job_ready;
  job_t job;

  itf_front #(.ValueBits(ValueBits)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_req_i,
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  itf_back #(.OutLimit(OutLimit)) u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_ready_o(job_ready),
    .job_i(job), .out_valid_o, .out_ready_i, .out_res_o
  );

`ifndef SYNTH
  a_trunc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.truncated |-> out_res_o.last)
    else $error("truncated without last");
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.empty_res |-> out_res_o.last)
    else $error("empty result not last");
`endif

endmodule
